// ===== src/m7d_pkg.sv =====
// Shared types, constants and helper functions for the modified UTF-7 decoder.
// No dependencies; the decoder top level, m7d_decode and m7d_emit import this package.
package m7d_pkg;

  // Character codes used by the decoder
  localparam logic [7:0] CH_AMP    = 8'h26;  // '&'
  localparam logic [7:0] CH_DASH   = 8'h2d;  // '-'
  localparam logic [7:0] CH_PLUS   = 8'h2b;  // '+'
  localparam logic [7:0] CH_COMMA  = 8'h2c;  // ','
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  // Offsets that map letters onto base64 values
  localparam logic [7:0] OFS_LOWER = 8'd71;  // 'a' maps to 26
  localparam logic [7:0] OFS_DIGIT = 8'd4;   // '0' maps to 52, added
  localparam logic [5:0] B64_PLUS  = 6'd62;
  localparam logic [5:0] B64_COMMA = 6'd63;

  // Base64 accumulator geometry
  localparam int unsigned ACC_W     = 22;
  localparam int unsigned BCNT_W    = 5;
  localparam int unsigned UNIT_W    = 16;
  localparam logic [BCNT_W-1:0] BITS_PER_LETTER = 5'd6;
  localparam logic [BCNT_W-1:0] BITS_PER_UNIT   = 5'd16;

  // UTF-8 limits and lead patterns
  localparam logic [15:0] UTF8_MAX1 = 16'h007f;
  localparam logic [15:0] UTF8_MAX2 = 16'h07ff;

  // Up to three bytes per decoded run
  localparam int unsigned RUN_MAX   = 3;
  localparam int unsigned RUN_CNT_W = 2;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_AMP    = 2'd1,
    MODE_B64    = 2'd2
  } m7d_mode_e;

  // Bytes produced by one input byte, in output order from index 0
  typedef struct packed {
    logic [RUN_CNT_W-1:0]       cnt;
    logic [RUN_MAX-1:0][7:0]    bytes;
  } m7d_run_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } m7d_b64_t;

  // Map a byte onto its modified-base64 value
  function automatic m7d_b64_t m7d_b64_value(logic [7:0] c);
    m7d_b64_t   res;
    logic [7:0] d;
    res = '0;
    d   = '0;
    if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      d       = c - CH_UP_A;
      res.ok  = 1'b1;
      res.val = d[5:0];
    end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      d       = c - OFS_LOWER;
      res.ok  = 1'b1;
      res.val = d[5:0];
    end else if (c inside {[CH_DIG_0:CH_DIG_9]}) begin
      d       = c + OFS_DIGIT;
      res.ok  = 1'b1;
      res.val = d[5:0];
    end else if (c == CH_PLUS) begin
      res.ok  = 1'b1;
      res.val = B64_PLUS;
    end else if (c == CH_COMMA) begin
      res.ok  = 1'b1;
      res.val = B64_COMMA;
    end
    return res;
  endfunction

  // Encode a 16-bit value as UTF-8; zero gives an empty run
  function automatic m7d_run_t m7d_utf8(logic [15:0] u);
    m7d_run_t r;
    r = '0;
    if (u == '0) begin
      r.cnt = 2'd0;
    end else if (u <= UTF8_MAX1) begin
      r.cnt      = 2'd1;
      r.bytes[0] = u[7:0];
    end else if (u <= UTF8_MAX2) begin
      r.cnt      = 2'd2;
      r.bytes[0] = {3'b110, u[10:6]};
      r.bytes[1] = {2'b10, u[5:0]};
    end else begin
      r.cnt      = 2'd3;
      r.bytes[0] = {4'b1110, u[15:12]};
      r.bytes[1] = {2'b10, u[11:6]};
      r.bytes[2] = {2'b10, u[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/m7d_in_if.sv =====
// Input channel of the modified UTF-7 decoder: one text byte per transfer.
// Depends on nothing.
interface m7d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== src/m7d_out_if.sv =====
// Output channel of the modified UTF-7 decoder: one UTF-8 byte per transfer.
// Depends on nothing.
interface m7d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== src/modified_utf7_to_utf8_decoder.sv =====
// Top level of the IMAP modified UTF-7 to UTF-8 decoder: input register,
// decode stage and result serializer. Depends on m7d_pkg, m7d_in_if,
// m7d_out_if, m7d_decode and m7d_emit.
//
//   Port        Dir  Payload                        Role
//   byte_in_i   in   in_byte[7:0]                   modified UTF-7 text byte
//   utf8_out_o  out  out_byte[7:0], last_of_run     UTF-8 byte, end-of-run flag
//
// A byte is registered at its transfer, decoded combinationally from the input
// register and loaded into the result register once that is free; its first
// UTF-8 byte is then offered from there. Each accepted byte occupies the
// three-byte result register until the bytes it yields (zero to three) have
// left, a new run loading as the last one leaves; that register sets the rate.
// Output stalls back up through the result register into the input register.
// rst_ni clears the mode, accumulator, bit count and all valid flags at once.
module modified_utf7_to_utf8_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  m7d_in_if.sink     byte_in_i,
  m7d_out_if.source  utf8_out_o
);
  import m7d_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       take;
  logic       advance;
  m7d_run_t   run;

  assign advance         = in_valid_q && take;
  assign byte_in_i.ready = !in_valid_q || advance;

  // Input register: hold a byte until the decode stage moves it on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_in_i.ready) begin
      in_valid_q <= byte_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in_i.valid && byte_in_i.ready) begin
      in_byte_q <= byte_in_i.in_byte;
    end
  end

  m7d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte_q),
    .advance_i (advance),
    .run_o     (run)
  );

  m7d_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .run_i      (run),
    .take_o     (take),
    .valid_o    (utf8_out_o.valid),
    .ready_i    (utf8_out_o.ready),
    .out_byte_o (utf8_out_o.out_byte),
    .last_o     (utf8_out_o.last_of_run)
  );

  a_held_byte_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("pending input byte lost or changed");

endmodule

// ===== src/m7d_decode.sv =====
// Decoder state (mode, base64 accumulator, bit count) and the per-byte decode.
// Depends on m7d_pkg.
module m7d_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        byte_i,
  input  logic              advance_i,
  output m7d_pkg::m7d_run_t run_o
);
  import m7d_pkg::*;

  m7d_mode_e           mode_q, mode_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [BCNT_W-1:0]   bcnt_q, bcnt_d;

  m7d_b64_t            letter;
  logic [ACC_W-1:0]    acc_sum;
  logic [BCNT_W-1:0]   bcnt_sum;
  logic [BCNT_W-1:0]   shift;
  logic [ACC_W-1:0]    unit_wide;
  logic [UNIT_W-1:0]   unit;
  m7d_run_t            run;

  // Gather one more letter and line up the next 16-bit unit
  assign letter    = m7d_b64_value(byte_i);
  assign acc_sum   = {acc_q[ACC_W-7:0], letter.val};
  assign bcnt_sum  = bcnt_q + BITS_PER_LETTER;
  assign shift     = bcnt_sum - BITS_PER_UNIT;
  assign unit_wide = acc_sum >> shift;
  assign unit      = unit_wide[UNIT_W-1:0];

  // Decode one byte against the current mode
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    bcnt_d = bcnt_q;
    run    = '0;
    case (mode_q)
      MODE_AMP: begin
        if (byte_i == CH_DASH) begin
          run.cnt      = 2'd1;
          run.bytes[0] = CH_AMP;
          mode_d       = MODE_DIRECT;
        end else if (letter.ok) begin
          acc_d  = ACC_W'(letter.val);
          bcnt_d = BITS_PER_LETTER;
          mode_d = MODE_B64;
        end else begin
          run.cnt      = 2'd2;
          run.bytes[0] = CH_AMP;
          run.bytes[1] = CH_DASH;
          mode_d       = MODE_DIRECT;
        end
      end
      MODE_B64: begin
        if (byte_i == CH_DASH) begin
          mode_d = MODE_DIRECT;
        end else if (letter.ok) begin
          acc_d = acc_sum;
          if (bcnt_sum >= BITS_PER_UNIT) begin
            run    = m7d_utf8(unit);
            bcnt_d = shift;
          end else begin
            bcnt_d = bcnt_sum;
          end
        end else begin
          run    = m7d_utf8({8'h00, byte_i});
          mode_d = MODE_DIRECT;
        end
      end
      default: begin
        if (byte_i == CH_AMP) begin
          mode_d = MODE_AMP;
        end else begin
          run = m7d_utf8({8'h00, byte_i});
        end
      end
    endcase
    // A zero byte ends the string and clears the mode, accumulator and bit count
    if (byte_i == CH_NUL) begin
      mode_d = MODE_DIRECT;
      acc_d  = '0;
      bcnt_d = '0;
    end
  end

  assign run_o = run;

  // Advance state only when the byte is handed to the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DIRECT;
      acc_q  <= '0;
      bcnt_q <= '0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      bcnt_q <= bcnt_d;
    end
  end

  // A full unit is always drained as soon as it is complete
  a_b64_count_below_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_B64) |-> (bcnt_q < BITS_PER_UNIT))
    else $error("base64 bit count holds a whole unit");

  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && byte_i == CH_NUL) |=>
      (mode_q == MODE_DIRECT && bcnt_q == '0 && acc_q == '0))
    else $error("zero byte did not return decoder to direct mode");

  a_amp_then_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && mode_q == MODE_AMP && !letter.ok) |=> (mode_q == MODE_DIRECT))
    else $error("non-letter after ampersand left shift mode open");

endmodule

// ===== src/m7d_emit.sv =====
// Result register: holds the bytes of one decoded run and sends them one
// per transfer. Depends on m7d_pkg.
module m7d_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  m7d_pkg::m7d_run_t run_i,
  output logic              take_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o
);
  import m7d_pkg::*;

  logic [RUN_MAX-1:0][7:0]  bytes_q;
  logic [RUN_CNT_W-1:0]     cnt_q;
  logic [RUN_CNT_W-1:0]     idx_q;
  logic                     last;
  logic                     xfer;

  assign valid_o    = (cnt_q != '0);
  assign last       = (idx_q == cnt_q - 2'd1);
  assign out_byte_o = bytes_q[idx_q];
  assign last_o     = last;
  assign xfer       = valid_o && ready_i;

  // Free for a new run when empty or when the last byte leaves now
  assign take_o = !valid_o || (xfer && last);

  // Load a new run, step to the next byte, or go empty after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= run_i.cnt;
      idx_q <= '0;
    end else if (xfer) begin
      if (last) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= run_i.bytes;
    end
  end

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (idx_q < cnt_q))
    else $error("byte index beyond held run");

  a_load_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && run_i.cnt != '0) |=> (valid_o && idx_q == '0))
    else $error("loaded run did not start at its first byte");

endmodule
